/* src/drrp_pkg.sv */
// shared types and constants of the download error retry policy block
package drrp_pkg;

    localparam int unsigned NUM_CHAN = 4;
    localparam int unsigned CH_W     = 2;

    // commands
    localparam logic [2:0] CMD_CHUNK_OK    = 3'd0;
    localparam logic [2:0] CMD_PLAYLIST_OK = 3'd1;
    localparam logic [2:0] CMD_CHUNK_ERR   = 3'd2;
    localparam logic [2:0] CMD_PLAYLIST_ERR = 3'd3;

    // media kinds
    localparam logic [2:0] KIND_AUDIO    = 3'd0;
    localparam logic [2:0] KIND_VIDEO    = 3'd1;
    localparam logic [2:0] KIND_AV       = 3'd2;
    localparam logic [2:0] KIND_SUBTITLE = 3'd3;

    // channels
    localparam logic [CH_W-1:0] CH_AUDIO    = 2'd0;
    localparam logic [CH_W-1:0] CH_VIDEO    = 2'd1;
    localparam logic [CH_W-1:0] CH_SUBTITLE = 2'd2;
    localparam logic [CH_W-1:0] CH_PLAYLIST = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_CONNECTION = 3'd1;

    // verdicts
    localparam logic [1:0] V_OK         = 2'd0;
    localparam logic [1:0] V_RETRY      = 2'd1;
    localparam logic [1:0] V_CHUNK_FAIL = 2'd2;
    localparam logic [1:0] V_LINK_FAIL  = 2'd3;

    // retry intervals
    localparam logic [10:0] INTERVAL_CONNECTION = 11'd2000;
    localparam logic [10:0] INTERVAL_OTHER      = 11'd200;

    // configuration register indexes
    localparam logic [1:0] REG_LIVE_MODE   = 2'd0;
    localparam logic [1:0] REG_RETRY_LIMIT = 2'd1;
    localparam logic [1:0] REG_CHUNK_LIMIT = 2'd2;
    localparam logic [1:0] REG_FAIL_TIME   = 2'd3;

    typedef struct packed {
        logic [7:0]  retry_count;
        logic [7:0]  failed_chunk_count;
        logic [2:0]  last_error;
        logic [31:0] error_start_time;
        logic        start_valid;
    } chan_rec_t;

    typedef struct packed {
        logic        live_mode;
        logic [7:0]  retry_limit;
        logic [7:0]  chunk_fail_limit;
        logic [31:0] fail_time_ms;
    } cfg_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        sat_inc = (v == 8'hFF) ? 8'hFF : v + 8'd1;
    endfunction

endpackage

/* src/drrp_calc.sv */
// error event evaluation: channel record update, verdict and retry interval
module drrp_calc (
    input  drrp_pkg::cfg_t      cfg,
    input  drrp_pkg::chan_rec_t rec,
    input  logic [2:0]          code,
    input  logic [31:0]         now,
    output drrp_pkg::chan_rec_t rec_next,
    output logic [1:0]          verdict,
    output logic [10:0]         interval
);

    logic [7:0]  rc_inc;
    logic        chunk_done;
    logic [7:0]  rc_counted;
    logic [7:0]  fc_counted;
    logic [1:0]  v_counted;
    logic [31:0] start_sel;
    logic        sv_sel;
    logic [31:0] elapsed;
    logic        time_up;

    always_comb
    begin
        rc_inc     = drrp_pkg::sat_inc(rec.retry_count);
        chunk_done = (rc_inc >= cfg.retry_limit);
        rc_counted = chunk_done ? 8'd0 : rc_inc;
        fc_counted = chunk_done ? drrp_pkg::sat_inc(rec.failed_chunk_count)
                                : rec.failed_chunk_count;
        v_counted  = chunk_done ? drrp_pkg::V_CHUNK_FAIL : drrp_pkg::V_RETRY;

        // vod restarts the clock on a code change, live only on the first error
        if (cfg.live_mode)
        begin
            start_sel = rec.start_valid ? rec.error_start_time : now;
            sv_sel    = 1'b1;
        end
        else
        begin
            start_sel = (rec.last_error != code) ? now : rec.error_start_time;
            sv_sel    = (rec.last_error != code) ? 1'b1 : rec.start_valid;
        end
        elapsed = now - start_sel;
        time_up = (elapsed >= cfg.fail_time_ms);

        rec_next                  = rec;
        rec_next.error_start_time = start_sel;
        rec_next.start_valid      = sv_sel;

        if (cfg.live_mode)
        begin
            rec_next.retry_count        = rc_counted;
            rec_next.failed_chunk_count = fc_counted;
            verdict = time_up ? drrp_pkg::V_LINK_FAIL : v_counted;
        end
        else if (code == drrp_pkg::ERR_CONNECTION)
        begin
            rec_next.last_error  = code;
            rec_next.retry_count = rc_inc;
            verdict = time_up ? drrp_pkg::V_LINK_FAIL : drrp_pkg::V_RETRY;
        end
        else
        begin
            rec_next.last_error  = code;
            rec_next.retry_count = rc_counted;
            if (fc_counted >= cfg.chunk_fail_limit)
            begin
                rec_next.failed_chunk_count = cfg.chunk_fail_limit;
                verdict = drrp_pkg::V_LINK_FAIL;
            end
            else
            begin
                rec_next.failed_chunk_count = fc_counted;
                verdict = v_counted;
            end
        end

        if (verdict != drrp_pkg::V_RETRY || code == drrp_pkg::ERR_NONE)
            interval = 11'd0;
        else if (code == drrp_pkg::ERR_CONNECTION)
            interval = drrp_pkg::INTERVAL_CONNECTION;
        else
            interval = drrp_pkg::INTERVAL_OTHER;
    end

endmodule

/* src/download_error_retry_policy_core.sv */
// top level of the download error retry policy block
//
// Usage: drive cmd, media_kind, err_code and now_ms with start high while
// busy is low; that edge accepts the event. Every accepted event, ignored
// ones included, returns exactly one result: verdict and retry_interval_ms
// are shown for one cycle with done high, registered at the edge after the accept.
// The receiver cannot stall; the result must be taken in that cycle.
// Busy is high during execution, so a new event is taken only after the
// last result is registered. The channel records sit in a four-entry memory;
// the accept edge reads one, the next writes an error's record back and registers the result.
// Configuration uses cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high and a transfer takes effect at once. Write
// configuration only while the block is idle.
// Reset (rst_n low, asynchronous) restores the register defaults and marks
// all channel records as cleared; no clearing pass is needed.
module download_error_retry_policy_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [2:0]  media_kind,
    input  logic [2:0]  err_code,
    input  logic [31:0] now_ms,
    output logic        done,
    output logic [1:0]  verdict,
    output logic [10:0] retry_interval_ms,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    drrp_pkg::cfg_t cfg_reg;

    drrp_pkg::chan_rec_t mem [drrp_pkg::NUM_CHAN];
    drrp_pkg::chan_rec_t rd_data_reg;
    logic [drrp_pkg::NUM_CHAN-1:0] valid_reg;
    logic rd_valid_reg;

    // latched event
    logic [drrp_pkg::CH_W-1:0] ch_reg;
    logic        act_reg;
    logic        is_err_reg;
    logic [2:0]  code_reg;
    logic [31:0] now_reg;

    logic [drrp_pkg::CH_W-1:0] ch_dec;
    logic        act_dec;
    logic        is_err_dec;
    logic [2:0]  code_dec;

    logic        accept;
    drrp_pkg::chan_rec_t rec_cur;
    drrp_pkg::chan_rec_t rec_upd;
    logic [1:0]  calc_verdict;
    logic [10:0] calc_interval;

    logic        done_reg;
    logic [1:0]  verdict_reg;
    logic [10:0] interval_reg;

    assign busy      = (state_reg == ST_EXEC);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // channel decode
    always_comb
    begin
        ch_dec     = drrp_pkg::CH_PLAYLIST;
        act_dec    = 1'b1;
        is_err_dec = 1'b0;
        code_dec   = drrp_pkg::ERR_NONE;
        unique case (cmd)
            drrp_pkg::CMD_CHUNK_OK, drrp_pkg::CMD_CHUNK_ERR:
            begin
                is_err_dec = (cmd == drrp_pkg::CMD_CHUNK_ERR);
                code_dec   = err_code;
                unique case (media_kind)
                    drrp_pkg::KIND_AUDIO:               ch_dec = drrp_pkg::CH_AUDIO;
                    drrp_pkg::KIND_VIDEO, drrp_pkg::KIND_AV: ch_dec = drrp_pkg::CH_VIDEO;
                    drrp_pkg::KIND_SUBTITLE:            ch_dec = drrp_pkg::CH_SUBTITLE;
                    default:                            act_dec = 1'b0;
                endcase
            end
            drrp_pkg::CMD_PLAYLIST_OK, drrp_pkg::CMD_PLAYLIST_ERR:
            begin
                is_err_dec = (cmd == drrp_pkg::CMD_PLAYLIST_ERR);
            end
            default: act_dec = 1'b0;
        endcase
    end

    // a cleared entry reads as all zero
    assign rec_cur = rd_valid_reg ? rd_data_reg : '0;

    drrp_calc u_calc (
        .cfg      (cfg_reg),
        .rec      (rec_cur),
        .code     (code_reg),
        .now      (now_reg),
        .rec_next (rec_upd),
        .verdict  (calc_verdict),
        .interval (calc_interval)
    );

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: state_next = accept ? ST_EXEC : ST_IDLE;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            done_reg     <= 1'b0;
            cfg_reg.live_mode        <= 1'b0;
            cfg_reg.retry_limit      <= 8'd3;
            cfg_reg.chunk_fail_limit <= 8'd10;
            cfg_reg.fail_time_ms     <= 32'd120000;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_EXEC);
            if (state_reg == ST_EXEC && act_reg)
                valid_reg[ch_reg] <= is_err_reg;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    drrp_pkg::REG_LIVE_MODE:   cfg_reg.live_mode        <= cfg_data[0];
                    drrp_pkg::REG_RETRY_LIMIT: cfg_reg.retry_limit      <= cfg_data[7:0];
                    drrp_pkg::REG_CHUNK_LIMIT: cfg_reg.chunk_fail_limit <= cfg_data[7:0];
                    drrp_pkg::REG_FAIL_TIME:   cfg_reg.fail_time_ms     <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // record memory: read at accept, write back in the execute cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg  <= mem[ch_dec];
            rd_valid_reg <= valid_reg[ch_dec];
            ch_reg       <= ch_dec;
            act_reg      <= act_dec;
            is_err_reg   <= is_err_dec;
            code_reg     <= code_dec;
            now_reg      <= now_ms;
        end
        if (state_reg == ST_EXEC && act_reg && is_err_reg)
            mem[ch_reg] <= rec_upd;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
        begin
            if (act_reg && is_err_reg)
            begin
                verdict_reg  <= calc_verdict;
                interval_reg <= calc_interval;
            end
            else
            begin
                verdict_reg  <= drrp_pkg::V_OK;
                interval_reg <= 11'd0;
            end
        end
    end

    assign done              = done_reg;
    assign verdict           = verdict_reg;
    assign retry_interval_ms = interval_reg;

endmodule

/* bench/tb_download_error_retry_policy_core.sv */
// testbench for the download error retry policy core, self-checking against an in-bench predictor
`timescale 1ns / 100ps

module tb_download_error_retry_policy_core;

    localparam int unsigned STALL_LIMIT   = 1000;
    localparam int unsigned SETTLE_CYCLES = 4;

    localparam logic [2:0] CMD_IGNORED   = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN  = 3'd4;
    localparam logic [2:0] ERR_NOT_FOUND = 3'd2;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd3;
    localparam logic [2:0] ERR_TIMEOUT   = 3'd4;
    localparam logic [2:0] ERR_AUTH      = 3'd5;
    localparam logic [2:0] ERR_OTHER     = 3'd6;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  kind;
        logic [2:0]  code;
        logic [31:0] now;
    } dl_event_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [10:0] interval;
    } judgment_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    logic [2:0]  cmd        = '0;
    logic [2:0]  media_kind = '0;
    logic [2:0]  err_code   = '0;
    logic [31:0] now_ms     = '0;
    logic        done;
    logic [1:0]  verdict;
    logic [10:0] retry_interval_ms;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index  = '0;
    logic [31:0] cfg_data   = '0;

    // predictor copy of the registers and channel records
    logic        live_rules;
    logic [7:0]  chunk_retry_limit;
    logic [7:0]  link_fail_limit;
    logic [31:0] fail_window_ms;
    logic [7:0]  chan_retries       [drrp_pkg::NUM_CHAN];
    logic [7:0]  chan_failed_chunks [drrp_pkg::NUM_CHAN];
    logic [2:0]  chan_last_err      [drrp_pkg::NUM_CHAN];
    logic [31:0] chan_err_start     [drrp_pkg::NUM_CHAN];
    logic        chan_start_set     [drrp_pkg::NUM_CHAN];

    dl_event_t   event_backlog[$];
    judgment_t   awaited_judgments[$];
    logic [31:0] wall_ms;
    logic        gaps_on = 1'b1;
    int          gap_left;
    int          idle_cycles;
    int          fail_count;
    int          events_accepted;
    int          judgments_checked;
    int          settings_run;
    int          verdict_tally[4];

    download_error_retry_policy_core u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .cmd               (cmd),
        .media_kind        (media_kind),
        .err_code          (err_code),
        .now_ms            (now_ms),
        .done              (done),
        .verdict           (verdict),
        .retry_interval_ms (retry_interval_ms),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] inc_sat8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic void clear_chan(input int unsigned ch);
        chan_retries[ch]       = '0;
        chan_failed_chunks[ch] = '0;
        chan_last_err[ch]      = drrp_pkg::ERR_NONE;
        chan_err_start[ch]     = '0;
        chan_start_set[ch]     = 1'b0;
    endfunction

    // one more try of the current chunk; the chunk fails once the limit is met
    function automatic logic [1:0] count_chunk_retry(input int unsigned ch);
        chan_retries[ch] = inc_sat8(chan_retries[ch]);
        if (chan_retries[ch] >= chunk_retry_limit)
        begin
            chan_retries[ch]       = '0;
            chan_failed_chunks[ch] = inc_sat8(chan_failed_chunks[ch]);
            return drrp_pkg::V_CHUNK_FAIL;
        end
        return drrp_pkg::V_RETRY;
    endfunction

    function automatic judgment_t judge_event(input dl_event_t ev);
        judgment_t   res;
        int unsigned ch;
        logic [2:0]  code;
        logic [31:0] elapsed;
        res.verdict  = drrp_pkg::V_OK;
        res.interval = '0;
        code         = ev.code;
        if (ev.cmd > drrp_pkg::CMD_PLAYLIST_ERR)
            return res;
        if (ev.cmd == drrp_pkg::CMD_PLAYLIST_OK || ev.cmd == drrp_pkg::CMD_PLAYLIST_ERR)
        begin
            ch   = 32'(drrp_pkg::CH_PLAYLIST);
            code = drrp_pkg::ERR_NONE;
        end
        else if (ev.kind == drrp_pkg::KIND_AUDIO)
            ch = 32'(drrp_pkg::CH_AUDIO);
        else if (ev.kind == drrp_pkg::KIND_VIDEO || ev.kind == drrp_pkg::KIND_AV)
            ch = 32'(drrp_pkg::CH_VIDEO);
        else if (ev.kind == drrp_pkg::KIND_SUBTITLE)
            ch = 32'(drrp_pkg::CH_SUBTITLE);
        else
            return res;
        if (ev.cmd == drrp_pkg::CMD_CHUNK_OK || ev.cmd == drrp_pkg::CMD_PLAYLIST_OK)
        begin
            clear_chan(ch);
            return res;
        end
        if (live_rules)
        begin
            res.verdict = count_chunk_retry(ch);
            // time limit runs from the first error, or from an earlier on-demand start
            if (!chan_start_set[ch])
            begin
                chan_err_start[ch] = ev.now;
                chan_start_set[ch] = 1'b1;
            end
            elapsed = ev.now - chan_err_start[ch];
            if (elapsed >= fail_window_ms)
                res.verdict = drrp_pkg::V_LINK_FAIL;
        end
        else
        begin
            if (chan_last_err[ch] != code)
            begin
                chan_err_start[ch] = ev.now;
                chan_start_set[ch] = 1'b1;
            end
            chan_last_err[ch] = code;
            if (code == drrp_pkg::ERR_CONNECTION)
            begin
                chan_retries[ch] = inc_sat8(chan_retries[ch]);
                elapsed          = ev.now - chan_err_start[ch];
                res.verdict      = (elapsed >= fail_window_ms) ? drrp_pkg::V_LINK_FAIL
                                                               : drrp_pkg::V_RETRY;
            end
            else
            begin
                res.verdict = count_chunk_retry(ch);
                if (chan_failed_chunks[ch] >= link_fail_limit)
                begin
                    chan_failed_chunks[ch] = link_fail_limit;
                    res.verdict            = drrp_pkg::V_LINK_FAIL;
                end
            end
        end
        if (res.verdict == drrp_pkg::V_RETRY)
            res.interval = (code == drrp_pkg::ERR_NONE)       ? 11'd0 :
                           (code == drrp_pkg::ERR_CONNECTION) ? drrp_pkg::INTERVAL_CONNECTION
                                                              : drrp_pkg::INTERVAL_OTHER;
        return res;
    endfunction

    function automatic void add_event(input logic [2:0] c, input logic [2:0] k,
                                      input logic [2:0] e, input logic [31:0] t);
        dl_event_t ev;
        ev.cmd  = c;
        ev.kind = k;
        ev.code = e;
        ev.now  = t;
        event_backlog.push_back(ev);
    endfunction

    function automatic logic [31:0] tick_clock();
        case ($urandom_range(0, 9))
            0:       wall_ms = $urandom;
            1, 2:    wall_ms = wall_ms + $urandom_range(0, 60000);
            default: wall_ms = wall_ms + $urandom_range(0, 1500);
        endcase
        return wall_ms;
    endfunction

    function automatic void add_error_burst(input logic [2:0] c, input logic [2:0] k,
                                            input logic [2:0] e, input int len,
                                            input int switch_pct);
        logic [2:0] code;
        code = e;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < switch_pct)
                code = 3'($urandom_range(0, 6));
            add_event(c, k, code, tick_clock());
        end
    endfunction

    // mostly error runs on one channel, often closed by a success, with noise between
    function automatic void add_random_events(input int n);
        int         made;
        int         len;
        logic [2:0] kind;
        logic [2:0] code;
        logic       playlist;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                add_event(3'($urandom_range(0, 4)), 3'($urandom_range(0, 4)),
                          3'($urandom_range(0, 6)),
                          $urandom_range(0, 1) ? $urandom : tick_clock());
                made++;
            end
            else
            begin
                playlist = ($urandom_range(0, 4) == 0);
                kind     = 3'($urandom_range(0, 3));
                len      = $urandom_range(1, 14);
                code     = ($urandom_range(0, 2) == 0) ? drrp_pkg::ERR_CONNECTION
                                                       : 3'($urandom_range(0, 6));
                add_error_burst(playlist ? drrp_pkg::CMD_PLAYLIST_ERR : drrp_pkg::CMD_CHUNK_ERR,
                                kind, code, len, 10);
                made += len;
                if ($urandom_range(0, 99) < 60)
                begin
                    add_event(playlist ? drrp_pkg::CMD_PLAYLIST_OK : drrp_pkg::CMD_CHUNK_OK,
                              kind, drrp_pkg::ERR_NONE, tick_clock());
                    made++;
                end
            end
        end
    endfunction

    task automatic settle();
        while (event_backlog.size() != 0 || awaited_judgments.size() != 0 || start)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic run_phase(input logic live, input logic [7:0] rlim, input logic [7:0] clim,
                             input logic [31:0] ftime, input int n_items, input int long_len,
                             input logic [2:0] long_code, input logic gaps);
        settle();
        write_reg(drrp_pkg::REG_LIVE_MODE, {31'd0, live});
        write_reg(drrp_pkg::REG_RETRY_LIMIT, {24'd0, rlim});
        write_reg(drrp_pkg::REG_CHUNK_LIMIT, {24'd0, clim});
        write_reg(drrp_pkg::REG_FAIL_TIME, ftime);
        cfg_valid <= 1'b0;
        @(negedge clk);
        gaps_on = gaps;
        if (long_len > 0)
            add_error_burst(drrp_pkg::CMD_CHUNK_ERR, drrp_pkg::KIND_AUDIO, long_code,
                            long_len, 0);
        add_random_events(n_items);
        settings_run++;
    endtask

    // driver: holds an event until the block takes it, then moves on or pauses
    always @(posedge clk or negedge rst_n)
    begin : driver
        dl_event_t nxt;
        if (!rst_n)
        begin
            start    <= 1'b0;
            gap_left = 0;
        end
        else if (!start || !busy)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (event_backlog.size() > 0)
            begin
                nxt = event_backlog.pop_front();
                cmd        <= nxt.cmd;
                media_kind <= nxt.kind;
                err_code   <= nxt.code;
                now_ms     <= nxt.now;
                start      <= 1'b1;
                if (gaps_on && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 11);
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: tracks register writes, predicts accepted events, checks results
    always @(posedge clk or negedge rst_n)
    begin : monitor
        dl_event_t ev;
        judgment_t want;
        if (!rst_n)
        begin
            live_rules        = 1'b0;
            chunk_retry_limit = 8'd3;
            link_fail_limit   = 8'd10;
            fail_window_ms    = 32'd120000;
            for (int i = 0; i < drrp_pkg::NUM_CHAN; i++)
                clear_chan(i);
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    drrp_pkg::REG_LIVE_MODE:   live_rules        = cfg_data[0];
                    drrp_pkg::REG_RETRY_LIMIT: chunk_retry_limit = cfg_data[7:0];
                    drrp_pkg::REG_CHUNK_LIMIT: link_fail_limit   = cfg_data[7:0];
                    drrp_pkg::REG_FAIL_TIME:   fail_window_ms    = cfg_data;
                    default: ;
                endcase
            end
            if (done)
            begin
                if (awaited_judgments.size() == 0)
                begin
                    $error("unexpected result: verdict %0d retry_interval_ms %0d",
                           verdict, retry_interval_ms);
                    fail_count++;
                end
                else
                begin
                    want = awaited_judgments.pop_front();
                    if (verdict !== want.verdict)
                    begin
                        $error("verdict: expected %0d, got %0d", want.verdict, verdict);
                        fail_count++;
                    end
                    if (retry_interval_ms !== want.interval)
                    begin
                        $error("retry_interval_ms: expected %0d, got %0d",
                               want.interval, retry_interval_ms);
                        fail_count++;
                    end
                    verdict_tally[want.verdict]++;
                    judgments_checked++;
                end
            end
            if (start && !busy)
            begin
                ev.cmd  = cmd;
                ev.kind = media_kind;
                ev.code = err_code;
                ev.now  = now_ms;
                awaited_judgments.push_back(judge_event(ev));
                events_accepted++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles, %0d results still awaited",
                     STALL_LIMIT, awaited_judgments.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        wall_ms = 32'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed events under the reset settings
        add_event(drrp_pkg::CMD_CHUNK_OK, drrp_pkg::KIND_AUDIO, drrp_pkg::ERR_NONE, 32'd0);
        add_event(drrp_pkg::CMD_PLAYLIST_OK, KIND_UNKNOWN, ERR_OTHER, 32'hFFFF_FFFF);
        add_event(drrp_pkg::CMD_CHUNK_ERR, drrp_pkg::KIND_AUDIO, ERR_NOT_FOUND, 32'd100);
        add_event(drrp_pkg::CMD_CHUNK_ERR, drrp_pkg::KIND_AUDIO, ERR_NOT_FOUND, 32'd200);
        add_event(drrp_pkg::CMD_CHUNK_ERR, drrp_pkg::KIND_AUDIO, ERR_NOT_FOUND, 32'd300);
        add_event(drrp_pkg::CMD_CHUNK_ERR, drrp_pkg::KIND_AUDIO, drrp_pkg::ERR_NONE, 32'd400);
        add_event(drrp_pkg::CMD_CHUNK_ERR, drrp_pkg::KIND_VIDEO, drrp_pkg::ERR_CONNECTION,
                  32'd1000);
        add_event(drrp_pkg::CMD_CHUNK_ERR, drrp_pkg::KIND_AV, drrp_pkg::ERR_CONNECTION,
                  32'd121000);
        add_event(drrp_pkg::CMD_CHUNK_ERR, drrp_pkg::KIND_SUBTITLE, ERR_TOO_LARGE, 32'd2000);
        add_event(drrp_pkg::CMD_CHUNK_ERR, drrp_pkg::KIND_SUBTITLE, ERR_TIMEOUT, 32'd2100);
        add_event(drrp_pkg::CMD_CHUNK_ERR, drrp_pkg::KIND_SUBTITLE, ERR_AUTH, 32'd2200);
        add_event(drrp_pkg::CMD_CHUNK_ERR, drrp_pkg::KIND_AUDIO, ERR_OTHER, 32'd2300);
        add_event(drrp_pkg::CMD_CHUNK_ERR, KIND_UNKNOWN, drrp_pkg::ERR_CONNECTION, 32'd2400);
        add_event(drrp_pkg::CMD_CHUNK_OK, KIND_UNKNOWN, drrp_pkg::ERR_NONE, 32'd2500);
        add_event(CMD_IGNORED, drrp_pkg::KIND_AUDIO, drrp_pkg::ERR_CONNECTION, 32'd2600);
        // playlist errors carry no code, so their retries wait zero
        add_event(drrp_pkg::CMD_PLAYLIST_ERR, drrp_pkg::KIND_AUDIO, ERR_OTHER, 32'd3000);
        add_event(drrp_pkg::CMD_PLAYLIST_ERR, drrp_pkg::KIND_VIDEO, drrp_pkg::ERR_CONNECTION,
                  32'd3100);
        add_event(drrp_pkg::CMD_PLAYLIST_ERR, drrp_pkg::KIND_SUBTITLE, ERR_NOT_FOUND,
                  32'd3200);
        add_event(drrp_pkg::CMD_CHUNK_OK, drrp_pkg::KIND_VIDEO, drrp_pkg::ERR_NONE, 32'd3300);
        // time difference across the 32-bit wrap
        add_event(drrp_pkg::CMD_CHUNK_ERR, drrp_pkg::KIND_VIDEO, drrp_pkg::ERR_CONNECTION,
                  32'hFFFF_FFF0);
        add_event(drrp_pkg::CMD_CHUNK_ERR, drrp_pkg::KIND_AV, drrp_pkg::ERR_CONNECTION,
                  32'h0000_0010);
        add_event(drrp_pkg::CMD_CHUNK_OK, drrp_pkg::KIND_SUBTITLE, drrp_pkg::ERR_NONE,
                  32'hFFFF_FFFF);
        add_event(drrp_pkg::CMD_CHUNK_OK, drrp_pkg::KIND_AV, drrp_pkg::ERR_NONE, 32'd20);
        add_event(drrp_pkg::CMD_PLAYLIST_OK, drrp_pkg::KIND_AUDIO, drrp_pkg::ERR_NONE, 32'd30);
        wall_ms = 32'd4000;
        add_random_events(80);
        settings_run = 1;

        run_phase(1'b0, 8'd1, 8'd1, 32'd0, 100, 0, drrp_pkg::ERR_NONE, 1'b1);
        run_phase(1'b0, 8'd255, 8'd255, 32'hFFFF_FFFF, 100, 260, drrp_pkg::ERR_CONNECTION,
                  1'b1);
        run_phase(1'b0, 8'd3, 8'd4, 32'd3000, 100, 0, drrp_pkg::ERR_NONE, 1'b0);
        run_phase(1'b1, 8'd2, 8'd10, 32'd5000, 100, 0, drrp_pkg::ERR_NONE, 1'b1);
        run_phase(1'b1, 8'd255, 8'd1, 32'd0, 100, 0, drrp_pkg::ERR_NONE, 1'b1);
        run_phase(1'b1, 8'd1, 8'd255, 32'hFFFF_FFFF, 100, 260, ERR_NOT_FOUND, 1'b1);
        run_phase(1'($urandom_range(0, 1)), 8'($urandom_range(1, 8)),
                  8'($urandom_range(1, 8)), $urandom_range(0, 20000), 100, 0,
                  drrp_pkg::ERR_NONE, 1'b0);
        settle();

        $display("%0d events judged under %0d register settings, %0d results checked",
                 events_accepted, settings_run, judgments_checked);
        $display("verdicts seen: ok %0d, retry %0d, chunk failed %0d, link failed %0d",
                 verdict_tally[drrp_pkg::V_OK], verdict_tally[drrp_pkg::V_RETRY],
                 verdict_tally[drrp_pkg::V_CHUNK_FAIL], verdict_tally[drrp_pkg::V_LINK_FAIL]);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* download_error_retry_policy_core.f */
src/drrp_pkg.sv
src/drrp_calc.sv
src/download_error_retry_policy_core.sv
bench/tb_download_error_retry_policy_core.sv
